// File: rtl/llsr_pkg.sv
// llsr_pkg: types and constants shared by the least-load server router.
// Used by llsr_ctrl, llsr_dp and the top level.
`timescale 1ns / 1ps
`default_nettype none
package llsr_pkg;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] sess_key;
    logic [15:0] server_port;
    logic [15:0] reported_load;
    logic [15:0] load_limit;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  reply_kind;
    logic [1:0]  result_code;
    logic [3:0]  entry_index;
    logic [15:0] entry_port;
    logic [15:0] entry_load;
    logic [15:0] entry_limit;
    logic [1:0]  entry_status;
    logic        entry_present;
    logic        last_item;
  } out_item_t;

  localparam logic [2:0] OP_REGISTER  = 3'd0;
  localparam logic [2:0] OP_HEARTBEAT = 3'd1;
  localparam logic [2:0] OP_ROUTE     = 3'd2;
  localparam logic [2:0] OP_LIST      = 3'd3;
  localparam logic [2:0] OP_TICK      = 3'd4;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_ROUTE = 2'd1;
  localparam logic [1:0] KIND_LIST  = 2'd2;

  localparam logic [1:0] RC_OK    = 2'd0;
  localparam logic [1:0] RC_NONE  = 2'd1;
  localparam logic [1:0] RC_FULL  = 2'd2;

  localparam logic [1:0] ST_ALIVE   = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [7:0] TIMEOUT_RESET = 8'd6;

  // controller -> datapath
  typedef struct packed {
    logic clr_scan;   // start a scan at entry 0
    logic step;       // evaluate current entry, advance index
    logic apply;      // perform the opcode's write
    logic emit;       // load the output register
    logic tick_inc;   // advance time
  } llsr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;  // index reached entries_used, or register / heartbeat hit
    logic hit;        // search hit (register / heartbeat) or route selection
    logic last_ent;   // list: current entry is the final one
  } llsr_sts_t;

endpackage
`default_nettype wire

// File: rtl/llsr_dp.sv
// llsr_dp: server table, scan index, search and selection registers.
// Depends on llsr_pkg; driven by llsr_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none
module llsr_dp import llsr_pkg::*; #(
  parameter int MAX_SERVERS = 16,
  parameter int IW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1,
  parameter int CW = $clog2(MAX_SERVERS + 1)
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire in_item_t   item,
  input  wire logic [7:0] timeout,
  input  wire llsr_cmd_t  cmd,
  output llsr_sts_t       sts,
  output out_item_t       res
);

  logic [15:0] port_mem  [MAX_SERVERS];
  logic [15:0] load_mem  [MAX_SERVERS];
  logic [15:0] limit_mem [MAX_SERVERS];
  logic [1:0]  stat_mem  [MAX_SERVERS];
  logic [31:0] owner_mem [MAX_SERVERS];
  logic [31:0] heard_mem [MAX_SERVERS];
  logic [MAX_SERVERS-1:0] own_vld_r;

  logic [CW-1:0] used_r;
  logic [31:0]   time_r;
  logic [CW-1:0] scan_r;
  logic          hit_r;
  logic [IW-1:0] sel_r;

  logic [IW-1:0] si;
  logic          elig;
  logic          hit_now;
  logic          last_ent;
  assign si = scan_r[IW-1:0];

  always_comb begin
    elig    = (stat_mem[si] == ST_ALIVE) && (load_mem[si] < limit_mem[si]);
    hit_now = 1'b0;
    case (item.opcode)
      OP_REGISTER:  hit_now = port_mem[si] == item.server_port;
      OP_HEARTBEAT: hit_now = own_vld_r[si] && owner_mem[si] == item.sess_key;
      OP_ROUTE:     hit_now = elig && (!hit_r || load_mem[si] < load_mem[sel_r]);
      default:      hit_now = 1'b0;
    endcase
  end

  assign sts.scan_done = (scan_r >= used_r) ||
                         (hit_r && (item.opcode == OP_REGISTER ||
                                    item.opcode == OP_HEARTBEAT));
  assign sts.hit = hit_r;
  assign last_ent = (scan_r + 1'b1) >= used_r;
  assign sts.last_ent = last_ent;

  logic [IW-1:0] tgt;
  logic          full_tbl;
  assign full_tbl = used_r >= CW'(MAX_SERVERS);
  assign tgt = hit_r ? sel_r : used_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      time_r    <= '0;
      own_vld_r <= '0;
      scan_r    <= '0;
      hit_r     <= 1'b0;
    end else begin
      if (cmd.clr_scan) begin
        scan_r    <= '0;
        hit_r     <= 1'b0;
      end
      if (cmd.step) begin
        if (item.opcode == OP_TICK) begin
          if ((stat_mem[si] == ST_ALIVE || stat_mem[si] == ST_FULL) &&
              (time_r - heard_mem[si]) > {24'd0, timeout}) begin
            stat_mem[si] <= ST_TIMEOUT;
            load_mem[si] <= '0;
          end
        end
        if (hit_now) begin
          hit_r <= 1'b1;
          sel_r <= si;
        end
        scan_r <= scan_r + 1'b1;
      end
      if (cmd.tick_inc) time_r <= time_r + 32'd1;
      if (cmd.apply) begin
        case (item.opcode)
          OP_REGISTER: if (hit_r || !full_tbl) begin
            if (!hit_r) begin
              used_r        <= used_r + 1'b1;
              port_mem[tgt] <= item.server_port;
            end
            // the target becomes the session's only owned entry
            for (int k = 0; k < MAX_SERVERS; k++)
              if (IW'(k) == tgt) own_vld_r[k] <= 1'b1;
              else if (owner_mem[k] == item.sess_key) own_vld_r[k] <= 1'b0;
            load_mem[tgt]  <= '0;
            limit_mem[tgt] <= item.load_limit;
            stat_mem[tgt]  <= ST_ALIVE;
            owner_mem[tgt] <= item.sess_key;
            heard_mem[tgt] <= time_r;
            sel_r          <= tgt;
            hit_r          <= 1'b1;
          end
          OP_HEARTBEAT: if (hit_r) begin
            load_mem[sel_r]  <= item.reported_load;
            limit_mem[sel_r] <= item.load_limit;
            heard_mem[sel_r] <= time_r;
            stat_mem[sel_r]  <= (item.reported_load >= item.load_limit) ?
                                ST_FULL : ST_ALIVE;
          end
          OP_ROUTE: if (hit_r && load_mem[sel_r] != 16'hFFFF)
            load_mem[sel_r] <= load_mem[sel_r] + 16'd1;
          default: ;
        endcase
      end
    end
  end

  // result register; list reads the current scan entry, others the selection
  logic [IW-1:0] ri;
  logic          pres;
  always_comb begin
    ri   = (item.opcode == OP_LIST) ? si : sel_r;
    pres = (item.opcode == OP_LIST) ? (used_r != '0) : hit_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res.reply_kind    <= (item.opcode == OP_REGISTER) ? KIND_ACK :
                           (item.opcode == OP_ROUTE) ? KIND_ROUTE : KIND_LIST;
      res.result_code   <= (item.opcode == OP_REGISTER && !hit_r) ? RC_FULL :
                           (item.opcode == OP_ROUTE && !hit_r) ? RC_NONE : RC_OK;
      res.entry_index   <= pres ? 4'(ri) : 4'd0;
      res.entry_port    <= pres ? port_mem[ri] : 16'd0;
      res.entry_load    <= pres ? load_mem[ri] : 16'd0;
      res.entry_limit   <= pres ? limit_mem[ri] : 16'd0;
      res.entry_status  <= pres ? stat_mem[ri] : 2'd0;
      res.entry_present <= pres;
      res.last_item     <= (item.opcode != OP_LIST) || last_ent;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(MAX_SERVERS)) else $error("table count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick_inc |=> time_r == $past(time_r) + 32'd1) else $error("time step");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_scan |=> scan_r == '0 && !hit_r) else $error("scan clear");

endmodule
`default_nettype wire

// File: rtl/llsr_ctrl.sv
// llsr_ctrl: sequencer for scan, write and result phases.
// Depends on llsr_pkg; drives llsr_dp.
`timescale 1ns / 1ps
`default_nettype none
module llsr_ctrl import llsr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_fire,
  input  wire logic [2:0] opcode,
  input  wire llsr_sts_t sts,
  input  wire logic      out_valid_r,
  input  wire logic      out_taken,
  output llsr_cmd_t      cmd,
  output logic           busy,
  output logic           set_valid
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_APPL = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_LIST = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_free;
  assign out_free = !out_valid_r || out_taken;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    set_valid = 1'b0;
    busy      = state_r != S_IDLE;
    case (state_r)
      S_IDLE: if (in_fire) begin
        cmd.clr_scan = 1'b1;
        cmd.tick_inc = opcode == OP_TICK;
        if (opcode inside {OP_REGISTER, OP_HEARTBEAT, OP_ROUTE, OP_TICK})
          state_nxt = S_SCAN;
        else if (opcode == OP_LIST) state_nxt = S_LIST;
      end
      S_SCAN: if (sts.scan_done) state_nxt = S_APPL;
              else cmd.step = 1'b1;
      S_APPL: begin
        cmd.apply = 1'b1;
        state_nxt = (opcode == OP_HEARTBEAT || opcode == OP_TICK) ? S_IDLE : S_EMIT;
      end
      S_EMIT: if (out_free) begin
        cmd.emit  = 1'b1;
        set_valid = 1'b1;
        state_nxt = S_IDLE;
      end
      S_LIST: if (out_free) begin
        cmd.emit  = 1'b1;
        set_valid = 1'b1;
        cmd.step  = 1'b1;
        if (sts.last_ent) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule
`default_nettype wire

// File: rtl/least_load_server_router_unit.sv
// Least-load server router: one input channel of opcodes, one result channel.
// Channels use valid/stall; an item moves when valid is high and stall low.
// The single configuration register timeout_ticks loads on cfg_we.
// Register, heartbeat, route and tick scan the table one entry per cycle.
// The table holds MAX_SERVERS entries (16 by default). A register or route
// result is loaded in the emit state, after the scan and write states, and the
// next item is taken back in idle; heartbeat and tick free the input after the write.
// Register and heartbeat stop scanning at the first match.
// List emits one result per entry, one per cycle while out_stall is low,
// the final one flagged by last_item; an empty table gives one result.
// Heartbeat, tick and unused opcodes give no result.
// One item is in work at a time; in_stall is high while the sequencer works.
// A finished result waits in the output register while out_stall is high;
// the sequencer holds until that register frees.
// Reset (rst_n low, synchronous) empties the table, clears time and
// restores timeout_ticks to 6; table storage needs no clearing.
// Depends on llsr_pkg, llsr_ctrl and llsr_dp.
`timescale 1ns / 1ps
`default_nettype none
module least_load_server_router_unit import llsr_pkg::*; #(
  parameter int MAX_SERVERS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_item,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_item,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_data
);

  logic       busy, set_valid, in_fire, out_taken;
  logic       out_valid_r;
  logic [7:0] timeout_r;
  in_item_t   item_r;
  llsr_cmd_t  cmd;
  llsr_sts_t  sts;

  assign in_stall  = busy;
  assign in_fire   = in_valid && !busy;
  assign out_taken = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;

  // capture the item while idle
  always_ff @(posedge clk) begin
    if (in_fire) item_r <= in_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) timeout_r <= cfg_data;
      if (set_valid)      out_valid_r <= 1'b1;
      else if (out_taken) out_valid_r <= 1'b0;
    end
  end

  llsr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
    .opcode(in_fire ? in_item.opcode : item_r.opcode),
    .sts(sts), .out_valid_r(out_valid_r), .out_taken(out_taken),
    .cmd(cmd), .busy(busy), .set_valid(set_valid)
  );

  llsr_dp #(.MAX_SERVERS(MAX_SERVERS)) u_dp (
    .clk(clk), .rst_n(rst_n), .item(item_r), .timeout(timeout_r),
    .cmd(cmd), .sts(sts), .res(out_item)
  );

  assert property (@(posedge clk) disable iff (!rst_n)
    set_valid |-> (!out_valid_r || !out_stall)) else $error("result overwritten");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r && $stable(out_item))
    else $error("stalled result changed");
  assert property (@(posedge clk) disable iff (!rst_n)
    set_valid |-> busy) else $error("result while idle");

endmodule
`default_nettype wire

// File: tb/sv/least_load_server_router_unit_test.sv
// Self-checking testbench for least_load_server_router_unit: drives opcode items,
// predicts the replies with a table model and compares each whole reply.
// Depends on llsr_pkg and the router RTL.
`timescale 1ns / 1ps
module least_load_server_router_unit_test;
  import llsr_pkg::*;

  localparam int NSRV = 16;
  localparam int CYCLE_LIMIT = 1500000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_item;
  logic out_valid;
  logic out_stall;
  out_item_t out_item;
  logic cfg_we;
  logic [7:0] cfg_data;

  least_load_server_router_unit #(.MAX_SERVERS(NSRV)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Table shadow: the router's state as the checker believes it to be.
  logic [7:0] tmo_ticks;
  int unsigned used_cnt;
  logic [31:0] now_ticks;
  logic [15:0] srv_port [NSRV];
  logic [15:0] srv_load [NSRV];
  logic [15:0] srv_limit [NSRV];
  logic [1:0] srv_status [NSRV];
  logic [31:0] srv_owner [NSRV];
  logic [31:0] srv_heard [NSRV];
  bit srv_owned [NSRV];

  in_item_t pending_items[$];
  out_item_t expected_replies[$];

  int mismatches;
  int replies_seen;
  int items_sent;
  bit hold_receiver;   // long receiver hold-off, owned by its own process
  bit pause_sender;
  longint cycles;

  // Append to the tail of the reply and item queues.
  function automatic void add_reply(out_item_t r);
    expected_replies.insert(expected_replies.size(), r);
  endfunction

  function automatic void add_item(in_item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic out_item_t make_reply(logic [1:0] kind, logic [1:0] code, int idx,
                                           bit present, bit last);
    out_item_t r;
    r = '0;
    r.reply_kind = kind;
    r.result_code = code;
    if (present) begin
      r.entry_index = idx[3:0];
      r.entry_port = srv_port[idx];
      r.entry_load = srv_load[idx];
      r.entry_limit = srv_limit[idx];
      r.entry_status = srv_status[idx];
      r.entry_present = 1'b1;
    end
    r.last_item = last;
    return r;
  endfunction

  // Advance the shadow table by one item and queue the replies it causes.
  task automatic predict_router(input in_item_t it);
    int idx;
    idx = -1;
    case (it.opcode)
      OP_REGISTER: begin
        for (int i = 0; i < used_cnt; i++)
          if (idx < 0 && srv_port[i] == it.server_port) idx = i;
        if (idx < 0 && used_cnt >= NSRV) begin
          add_reply(make_reply(KIND_ACK, RC_FULL, 0, 0, 1));
        end else begin
          if (idx < 0) begin
            idx = used_cnt;
            used_cnt++;
            srv_port[idx] = it.server_port;
          end
          for (int i = 0; i < NSRV; i++)
            if (srv_owned[i] && srv_owner[i] == it.sess_key) srv_owned[i] = 0;
          srv_load[idx] = '0;
          srv_limit[idx] = it.load_limit;
          srv_status[idx] = ST_ALIVE;
          srv_owner[idx] = it.sess_key;
          srv_owned[idx] = 1;
          srv_heard[idx] = now_ticks;
          add_reply(make_reply(KIND_ACK, RC_OK, idx, 1, 1));
        end
      end
      OP_HEARTBEAT: begin
        for (int i = 0; i < used_cnt; i++)
          if (idx < 0 && srv_owned[i] && srv_owner[i] == it.sess_key) idx = i;
        if (idx >= 0) begin
          srv_load[idx] = it.reported_load;
          srv_limit[idx] = it.load_limit;
          srv_heard[idx] = now_ticks;
          srv_status[idx] = (it.reported_load >= it.load_limit) ? ST_FULL : ST_ALIVE;
        end
      end
      OP_ROUTE: begin
        for (int i = 0; i < used_cnt; i++)
          if (srv_status[i] == ST_ALIVE && srv_load[i] < srv_limit[i])
            if (idx < 0 || srv_load[i] < srv_load[idx]) idx = i;
        if (idx < 0) begin
          add_reply(make_reply(KIND_ROUTE, RC_NONE, 0, 0, 1));
        end else begin
          if (srv_load[idx] != 16'hFFFF) srv_load[idx] = srv_load[idx] + 16'd1;
          add_reply(make_reply(KIND_ROUTE, RC_OK, idx, 1, 1));
        end
      end
      OP_LIST: begin
        if (used_cnt == 0)
          add_reply(make_reply(KIND_LIST, RC_OK, 0, 0, 1));
        for (int i = 0; i < used_cnt; i++)
          add_reply(make_reply(KIND_LIST, RC_OK, i, 1, i == used_cnt - 1));
      end
      OP_TICK: begin
        now_ticks = now_ticks + 32'd1;
        for (int i = 0; i < used_cnt; i++)
          if ((srv_status[i] == ST_ALIVE || srv_status[i] == ST_FULL) &&
              (now_ticks - srv_heard[i]) > {24'd0, tmo_ticks}) begin
            srv_status[i] = ST_TIMEOUT;
            srv_load[i] = '0;
          end
      end
      default: ;  // unused opcodes: drop silently
    endcase
  endtask

  function automatic in_item_t rand_item(logic [2:0] op);
    in_item_t it;
    it.opcode = op;
    it.sess_key = $urandom();
    it.server_port = 16'($urandom());
    it.reported_load = 16'($urandom());
    it.load_limit = 16'($urandom());
    return it;
  endfunction

  // Realistic item: small pools of sessions and ports so that updates,
  // takeovers and heartbeats land on known entries.
  function automatic in_item_t pool_item();
    in_item_t it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    it = rand_item(OP_ROUTE);
    it.sess_key = 32'hA000_0000 + 32'($urandom_range(0, 19));
    it.server_port = 16'd8000 + 16'($urandom_range(0, 21));
    it.load_limit = 16'($urandom_range(0, 40));
    it.reported_load = 16'($urandom_range(0, 45));
    if ($urandom_range(0, 9) == 0) it.load_limit = 16'($urandom());
    if ($urandom_range(0, 19) == 0) it.reported_load = 16'hFFFF;
    if (pick < 20) it.opcode = OP_REGISTER;
    else if (pick < 45) it.opcode = OP_HEARTBEAT;
    else if (pick < 75) it.opcode = OP_ROUTE;
    else if (pick < 82) it.opcode = OP_LIST;
    else if (pick < 97) it.opcode = OP_TICK;
    else it.opcode = 3'($urandom_range(5, 7));
    return it;
  endfunction

  // Write timeout_ticks while the router is idle; the shadow follows.
  task automatic write_timeout(input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    tmo_ticks = val;
  endtask

  // Wait until every queued item is out and every reply is back, then let
  // a possible silent item (heartbeat, tick) finish its scan.
  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_replies.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Driver: offer the next item after a random gap; hold it while stalled.
  int send_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_item <= '0;
      send_gap <= 0;
    end else if (in_valid && !in_stall) begin
      predict_router(in_item);
      items_sent++;
      if (pending_items.size() != 0 && !pause_sender && $urandom_range(0, 2) == 0) begin
        in_item <= pending_items.pop_front();  // back-to-back
      end else begin
        in_valid <= 1'b0;
        send_gap <= $urandom_range(0, 10);
      end
    end else if (!in_valid) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (pending_items.size() != 0 && !pause_sender) begin
        in_item <= pending_items.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // Monitor: compare every accepted reply with the oldest expectation.
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        replies_seen++;
        if (expected_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected reply %p", out_item);
        end else begin
          out_item_t want;
          want = expected_replies.pop_front();
          if (out_item !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("reply mismatch: expected %p actual %p", want, out_item);
          end
        end
      end
      if (hold_receiver) begin
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (out_valid && !out_stall) begin
        // one reply taken: draw the wait before the next one
        stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  // Hold the receiver off for a long stretch while the sender keeps going.
  initial begin
    hold_receiver = 1'b0;
    wait (items_sent > 60);
    @(posedge clk);
    hold_receiver = 1'b1;
    repeat (400) @(posedge clk);
    hold_receiver = 1'b0;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d replies outstanding",
                 cycles, expected_replies.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    in_item_t it;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    mismatches = 0;
    replies_seen = 0;
    items_sent = 0;
    pause_sender = 1'b0;
    tmo_ticks = TIMEOUT_RESET;
    used_cnt = 0;
    now_ticks = '0;
    for (int i = 0; i < NSRV; i++) begin
      srv_owned[i] = 0;
      srv_status[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, then extremes, takeover and table full.
    add_item(rand_item(OP_LIST));
    add_item(rand_item(OP_ROUTE));   // no server available
    add_item(rand_item(3'd5));
    add_item(rand_item(3'd7));
    it = rand_item(OP_HEARTBEAT); add_item(it);  // unknown session
    it = rand_item(OP_REGISTER);
    it.sess_key = 32'hFFFF_FFFF; it.server_port = 16'hFFFF; it.load_limit = 16'hFFFF;
    add_item(it);
    it.opcode = OP_HEARTBEAT; it.reported_load = 16'hFFFE;
    add_item(it);
    add_item(rand_item(OP_ROUTE));   // saturates toward the limit
    it = rand_item(OP_REGISTER);
    it.sess_key = 32'h0; it.server_port = 16'h0; it.load_limit = 16'h0;
    add_item(it);                    // limit 0: never routable
    it.server_port = 16'hFFFF; it.load_limit = 16'd3;
    add_item(it);                    // takeover of known port
    it.opcode = OP_HEARTBEAT; it.reported_load = 16'd3;
    add_item(it);                    // load at limit: full
    for (int i = 0; i < 15; i++) begin
      it = rand_item(OP_REGISTER);
      it.server_port = 16'd100 + i[15:0];
      it.sess_key = 32'h5000 + i;
      add_item(it);
    end
    add_item(rand_item(OP_LIST));
    drain();

    // Saturation: heartbeat to 65534 under the top limit, then route once and list.
    it = rand_item(OP_REGISTER);
    it.server_port = 16'hFFFF; it.sess_key = 32'hCAFE; it.load_limit = 16'hFFFF;
    add_item(it);
    it.opcode = OP_HEARTBEAT; it.reported_load = 16'hFFFE;
    add_item(it);
    it.load_limit = 16'hFFFF; it.reported_load = 16'hFFFF;
    add_item(rand_item(OP_ROUTE));
    add_item(rand_item(OP_LIST));
    drain();

    // Random phases under several timeouts, with a reset-free table wipe by
    // timeout ticks at the extremes.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_timeout(8'd1);
        1: write_timeout(8'd255);
        2: write_timeout(8'd0);
        3: write_timeout(8'($urandom_range(2, 12)));
        default: write_timeout(8'd6);
      endcase
      for (int n = 0; n < 80; n++)
        add_item(($urandom_range(0, 19) == 0) ? rand_item(3'($urandom()))
                                              : pool_item());
      if (phase == 2) begin
        wait (pending_items.size() < 40);
        pause_sender = 1'b1;          // let every reply come back first
        while (expected_replies.size() != 0 || in_valid) @(posedge clk);
        pause_sender = 1'b0;
      end
      drain();
    end
    write_timeout(8'($urandom()));
    for (int n = 0; n < 20; n++) add_item(pool_item());
    drain();

    $display("covered %0d items and %0d replies over six timeout settings",
             items_sent, replies_seen);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0 && expected_replies.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
